// ----- src/midpoint_ellipse_arc_points_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the quarter-arc point generator
// Concurrent assertion shorthands, with and without a reset guard.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_ARC_POINTS_ASSERT_SVH
`define MIDPOINT_ELLIPSE_ARC_POINTS_ASSERT_SVH

// Checked on every rising edge while reset is released.
`define MEA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define MEA_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/mea_pkg.sv -----
// ----------------------------------------------------------------------------
// mea_pkg
// Widths, datapath commands and status shared by the arc point generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mea_pkg;

    localparam int COORD_W = 16;
    localparam int RAD_W   = 6;
    localparam int OFF_W   = 7;
    localparam int SQ_W    = 11;
    localparam int TMP_W   = 12;
    localparam int PROD_W  = 24;
    localparam int SLOPE_W = 19;
    localparam int DEC_W   = 26;

    localparam logic [RAD_W-1:0] RADIUS_MAX = 6'd32;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SQ_RX,
        CMD_SQ_RY,
        CMD_R1_MUL,
        CMD_R1_START,
        CMD_R1_STEP,
        CMD_R2_X2,
        CMD_R2_MA,
        CMD_R2_Y2,
        CMD_R2_MB,
        CMD_R2_ACC,
        CMD_R2_START,
        CMD_R2_STEP,
        CMD_C_START,
        CMD_C_STEP,
        CMD_C_SWAP,
        CMD_EMPTY
    } t_cmd;

    typedef struct packed {
        logic rad_eq;
        logic rx_zero;
        logic ry_zero;
        logic circ_more;
        logic r1_more;
        logic r2_more;
    } t_status;

endpackage

`default_nettype wire

// ----- src/mea_if.sv -----
// ----------------------------------------------------------------------------
// Request and point channels
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface mea_req_if;
    logic                                valid;
    logic                                ready;
    logic signed [mea_pkg::COORD_W-1:0]  center_x;
    logic signed [mea_pkg::COORD_W-1:0]  center_y;
    logic        [mea_pkg::RAD_W-1:0]    radius_x;
    logic        [mea_pkg::RAD_W-1:0]    radius_y;

    modport source (output valid, center_x, center_y, radius_x, radius_y, input ready);
    modport sink   (input valid, center_x, center_y, radius_x, radius_y, output ready);
endinterface

interface mea_pt_if;
    logic                                valid;
    logic                                ready;
    logic signed [mea_pkg::COORD_W-1:0]  point_x;
    logic signed [mea_pkg::COORD_W-1:0]  point_y;
    logic                                last;
    logic                                empty_res;

    modport source (output valid, point_x, point_y, last, empty_res, input ready);
    modport sink   (input valid, point_x, point_y, last, empty_res, output ready);
endinterface

`default_nettype wire

// ----- src/midpoint_ellipse_arc_points.sv -----
// A circle request goes from the load straight to the circle start terms; an ellipse request
// first squares both radii and forms the region-one start terms on one shared multiplier,
// and a second multiply sequence sets up region two. Within each arc loop, points leave
// back to back while the sink takes them.
// A new request is taken only after the last point of the previous one has been produced.
// Reset is synchronous and active low; it clears the sequencer state and the output valid.
// ----------------------------------------------------------------------------
// midpoint_ellipse_arc_points
// Quarter-arc point generator for an axis-aligned circle or ellipse.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_ellipse_arc_points (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mea_req_if.sink    i_req,
    mea_pt_if.source   o_pt
);
    import mea_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;
    logic    out_valid;

    mea_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_pt.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mea_dp u_dp (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_center_x  (i_req.center_x),
        .i_center_y  (i_req.center_y),
        .i_radius_x  (i_req.radius_x),
        .i_radius_y  (i_req.radius_y),
        .o_status    (status),
        .o_point_x   (o_pt.point_x),
        .o_point_y   (o_pt.point_y),
        .o_last      (o_pt.last),
        .o_empty_res (o_pt.empty_res)
    );

    assign i_req.ready = in_ready;
    assign o_pt.valid  = out_valid;

endmodule

`default_nettype wire

// ----- src/mea_ctrl.sv -----
// ----------------------------------------------------------------------------
// mea_ctrl
// Sequencer: steps the datapath through setup and the arc loops.
// ----------------------------------------------------------------------------
`default_nettype none

module mea_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire mea_pkg::t_status i_status,
    output mea_pkg::t_cmd         o_cmd
);
    import mea_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_EMPTY,
        S_CIRC,
        S_SWAP,
        S_SQ_RY,
        S_R1_MUL,
        S_R1_START,
        S_R1,
        S_R2_MA,
        S_R2_Y2,
        S_R2_MB,
        S_R2_ACC,
        S_R2_START,
        S_R2
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;
    logic   emit;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        emit    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.rad_eq) begin
                    if (i_status.rx_zero) begin
                        n_state = S_EMPTY;
                    end else begin
                        o_cmd   = CMD_C_START;
                        n_state = S_CIRC;
                    end
                end else if (i_status.ry_zero) begin
                    n_state = S_EMPTY;
                end else begin
                    o_cmd   = CMD_SQ_RX;
                    n_state = S_SQ_RY;
                end
            end
            S_EMPTY: begin
                if (slot_free) begin
                    o_cmd   = CMD_EMPTY;
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CIRC: begin
                if (!i_status.circ_more) begin
                    n_state = S_IDLE;
                end else if (slot_free) begin
                    o_cmd   = CMD_C_STEP;
                    emit    = 1'b1;
                    n_state = S_SWAP;
                end
            end
            S_SWAP: begin
                if (slot_free) begin
                    o_cmd   = CMD_C_SWAP;
                    emit    = 1'b1;
                    n_state = S_CIRC;
                end
            end
            S_SQ_RY: begin
                o_cmd   = CMD_SQ_RY;
                n_state = S_R1_MUL;
            end
            S_R1_MUL: begin
                o_cmd   = CMD_R1_MUL;
                n_state = S_R1_START;
            end
            S_R1_START: begin
                o_cmd   = CMD_R1_START;
                n_state = S_R1;
            end
            S_R1: begin
                if (!i_status.r1_more) begin
                    o_cmd   = CMD_R2_X2;
                    n_state = S_R2_MA;
                end else if (slot_free) begin
                    o_cmd = CMD_R1_STEP;
                    emit  = 1'b1;
                end
            end
            S_R2_MA: begin
                o_cmd   = CMD_R2_MA;
                n_state = S_R2_Y2;
            end
            S_R2_Y2: begin
                o_cmd   = CMD_R2_Y2;
                n_state = S_R2_MB;
            end
            S_R2_MB: begin
                o_cmd   = CMD_R2_MB;
                n_state = S_R2_ACC;
            end
            S_R2_ACC: begin
                o_cmd   = CMD_R2_ACC;
                n_state = S_R2_START;
            end
            S_R2_START: begin
                o_cmd   = CMD_R2_START;
                n_state = S_R2;
            end
            S_R2: begin
                if (!i_status.r2_more) begin
                    n_state = S_IDLE;
                end else if (slot_free) begin
                    o_cmd = CMD_R2_STEP;
                    emit  = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ----- src/mea_dp.sv -----
// ----------------------------------------------------------------------------
// mea_dp
// Datapath: offsets, slope terms, decision term, shared multiplier, output.
// ----------------------------------------------------------------------------
`default_nettype none

module mea_dp (
    input  wire logic                              i_clk,
    input  wire mea_pkg::t_cmd                     i_cmd,
    input  wire logic signed [mea_pkg::COORD_W-1:0] i_center_x,
    input  wire logic signed [mea_pkg::COORD_W-1:0] i_center_y,
    input  wire logic        [mea_pkg::RAD_W-1:0]   i_radius_x,
    input  wire logic        [mea_pkg::RAD_W-1:0]   i_radius_y,
    output mea_pkg::t_status                       o_status,
    output logic signed      [mea_pkg::COORD_W-1:0] o_point_x,
    output logic signed      [mea_pkg::COORD_W-1:0] o_point_y,
    output logic                                   o_last,
    output logic                                   o_empty_res
);
    import mea_pkg::*;

    logic signed [COORD_W-1:0] r_cx, r_cy;
    logic        [RAD_W-1:0]   r_rx, r_ry;
    logic        [SQ_W-1:0]    r_rx2, r_ry2;
    logic        [OFF_W-1:0]   r_x, r_y;
    logic signed [SLOPE_W-1:0] r_dx, r_dy;
    logic signed [DEC_W-1:0]   r_f;
    logic        [TMP_W-1:0]   r_tmp;
    logic        [PROD_W-1:0]  r_prod;
    logic signed [DEC_W-1:0]   r_acc;
    logic signed [COORD_W-1:0] r_px, r_py;
    logic                      r_last, r_empty;

    logic        [TMP_W-1:0]   mul_a, mul_b;
    logic        [PROD_W-1:0]  mul;
    logic        [OFF_W-1:0]   ym1;
    logic        [SQ_W:0]      rx2_p2, ry2_p2;

    logic signed [DEC_W-1:0]   e_rx, e_rx2, e_ry2, e_rx2q, e_ry2q, e_prod;
    logic signed [SLOPE_W-1:0] s_rx2x2, s_ry2x2, s_dy0;

    logic                      c1;
    logic        [OFF_W-1:0]   x1, y1;
    logic signed [SLOPE_W-1:0] dx1, dy1;
    logic signed [DEC_W-1:0]   f1a, f1;
    logic                      last1;

    logic                      c2;
    logic        [OFF_W-1:0]   x2, y2;
    logic signed [SLOPE_W-1:0] dx2, dy2;
    logic signed [DEC_W-1:0]   f2a, f2;

    logic        [OFF_W-1:0]   ci, cj;
    logic signed [DEC_W-1:0]   e_ci2, e_y2x, fc;

    logic signed [DEC_W-1:0]   f_r1_start, f_r2_start, f_c_start;
    logic        [RAD_W-1:0]   rx_sat, ry_sat;

    assign rx_sat = (i_radius_x > RADIUS_MAX) ? RADIUS_MAX : i_radius_x;
    assign ry_sat = (i_radius_y > RADIUS_MAX) ? RADIUS_MAX : i_radius_y;

    // Shared multiplier; operands chosen by the current command.
    assign ym1 = (r_y == '0) ? OFF_W'(1) : r_y - OFF_W'(1);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd)
            CMD_SQ_RX: begin
                mul_a = TMP_W'(r_rx);
                mul_b = TMP_W'(r_rx);
            end
            CMD_SQ_RY: begin
                mul_a = TMP_W'(r_ry);
                mul_b = TMP_W'(r_ry);
            end
            CMD_R1_MUL: begin
                mul_a = TMP_W'(r_rx2);
                mul_b = TMP_W'(r_ry);
            end
            CMD_R2_X2: begin
                mul_a = TMP_W'(r_x);
                mul_b = TMP_W'(r_x);
            end
            CMD_R2_MA: begin
                mul_a = TMP_W'(r_ry2);
                mul_b = r_tmp;
            end
            CMD_R2_Y2: begin
                mul_a = TMP_W'(ym1);
                mul_b = TMP_W'(ym1);
            end
            CMD_R2_MB: begin
                mul_a = TMP_W'(r_rx2);
                mul_b = r_tmp;
            end
            CMD_R2_ACC: begin
                mul_a = TMP_W'(r_rx2);
                mul_b = TMP_W'(r_ry2);
            end
            default: begin
            end
        endcase
    end

    assign mul = mul_a * mul_b;

    assign rx2_p2 = {1'b0, r_rx2} + (SQ_W+1)'(2);
    assign ry2_p2 = {1'b0, r_ry2} + (SQ_W+1)'(2);

    assign e_rx    = $signed({{(DEC_W-RAD_W){1'b0}}, r_rx});
    assign e_rx2   = $signed({{(DEC_W-SQ_W){1'b0}}, r_rx2});
    assign e_ry2   = $signed({{(DEC_W-SQ_W){1'b0}}, r_ry2});
    assign e_rx2q  = $signed({{(DEC_W-SQ_W+1){1'b0}}, rx2_p2[SQ_W:2]});
    assign e_ry2q  = $signed({{(DEC_W-SQ_W+1){1'b0}}, ry2_p2[SQ_W:2]});
    assign e_prod  = $signed({{(DEC_W-PROD_W){1'b0}}, r_prod});
    assign s_rx2x2 = $signed({{(SLOPE_W-SQ_W-1){1'b0}}, r_rx2, 1'b0});
    assign s_ry2x2 = $signed({{(SLOPE_W-SQ_W-1){1'b0}}, r_ry2, 1'b0});
    assign s_dy0   = $signed({1'b0, r_prod[SLOPE_W-3:0], 1'b0});

    // Start terms: the quarter term is folded in as floor((c + 2) / 4).
    assign f_r1_start = e_ry2 - e_prod + e_rx2q;
    assign f_r2_start = r_acc - e_prod + e_ry2q;
    assign f_c_start  = DEC_W'(1) - e_rx;

    // Region one step.
    assign c1    = (r_f >= 0);
    assign y1    = c1 ? r_y - OFF_W'(1) : r_y;
    assign dy1   = c1 ? r_dy - s_rx2x2 : r_dy;
    assign f1a   = c1 ? r_f - DEC_W'(dy1) : r_f;
    assign x1    = r_x + OFF_W'(1);
    assign dx1   = r_dx + s_ry2x2;
    assign f1    = f1a + DEC_W'(dx1) + e_ry2;
    assign last1 = !(dx1 < dy1) && (y1 == '0);

    // Region two step.
    assign c2  = (r_f <= 0);
    assign x2  = c2 ? r_x + OFF_W'(1) : r_x;
    assign dx2 = c2 ? r_dx + s_ry2x2 : r_dx;
    assign f2a = c2 ? r_f + DEC_W'(dx2) : r_f;
    assign y2  = r_y - OFF_W'(1);
    assign dy2 = r_dy - s_rx2x2;
    assign f2  = f2a + e_rx2 - DEC_W'(dy2);

    // Circle step.
    assign ci    = r_x + OFF_W'(1);
    assign e_ci2 = $signed({{(DEC_W-OFF_W-1){1'b0}}, ci, 1'b0});
    assign e_y2x = $signed({{(DEC_W-OFF_W-1){1'b0}}, r_y, 1'b0});
    assign fc    = (r_f < 0) ? r_f + e_ci2 - DEC_W'(1) : r_f + e_ci2 - e_y2x;
    assign cj    = (r_f < 0) ? r_y : r_y - OFF_W'(1);

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_LOAD: begin
                r_cx <= i_center_x;
                r_cy <= i_center_y;
                r_rx <= rx_sat;
                r_ry <= ry_sat;
            end
            CMD_SQ_RX: begin
                r_rx2 <= mul[SQ_W-1:0];
            end
            CMD_SQ_RY: begin
                r_ry2 <= mul[SQ_W-1:0];
            end
            CMD_R1_MUL: begin
                r_prod <= mul;
            end
            CMD_R1_START: begin
                r_x  <= '0;
                r_y  <= OFF_W'(r_ry);
                r_dx <= '0;
                r_dy <= s_dy0;
                r_f  <= f_r1_start;
            end
            CMD_R1_STEP: begin
                r_x     <= x1;
                r_y     <= y1;
                r_dx    <= dx1;
                r_dy    <= dy1;
                r_f     <= f1;
                r_px    <= r_cx + $signed({{(COORD_W-OFF_W){1'b0}}, x1});
                r_py    <= r_cy + $signed({{(COORD_W-OFF_W){1'b0}}, y1});
                r_last  <= last1;
                r_empty <= 1'b0;
            end
            CMD_R2_X2: begin
                r_tmp <= mul[TMP_W-1:0] + TMP_W'(r_x);
            end
            CMD_R2_MA: begin
                r_prod <= mul;
            end
            CMD_R2_Y2: begin
                r_tmp <= mul[TMP_W-1:0];
                r_acc <= e_prod;
            end
            CMD_R2_MB: begin
                r_prod <= mul;
            end
            CMD_R2_ACC: begin
                r_acc  <= r_acc + e_prod;
                r_prod <= mul;
            end
            CMD_R2_START: begin
                r_f <= f_r2_start;
            end
            CMD_R2_STEP: begin
                r_x     <= x2;
                r_y     <= y2;
                r_dx    <= dx2;
                r_dy    <= dy2;
                r_f     <= f2;
                r_px    <= r_cx + $signed({{(COORD_W-OFF_W){1'b0}}, x2});
                r_py    <= r_cy + $signed({{(COORD_W-OFF_W){1'b0}}, y2});
                r_last  <= (y2 == '0);
                r_empty <= 1'b0;
            end
            CMD_C_START: begin
                r_x <= '0;
                r_y <= OFF_W'(r_rx);
                r_f <= f_c_start;
            end
            CMD_C_STEP: begin
                r_x     <= ci;
                r_y     <= cj;
                r_f     <= fc;
                r_px    <= r_cx + $signed({{(COORD_W-OFF_W){1'b0}}, ci});
                r_py    <= r_cy + $signed({{(COORD_W-OFF_W){1'b0}}, cj});
                r_last  <= 1'b0;
                r_empty <= 1'b0;
            end
            CMD_C_SWAP: begin
                r_px    <= r_cx + $signed({{(COORD_W-OFF_W){1'b0}}, r_y});
                r_py    <= r_cy + $signed({{(COORD_W-OFF_W){1'b0}}, r_x});
                r_last  <= !(r_x < r_y);
                r_empty <= 1'b0;
            end
            CMD_EMPTY: begin
                r_px    <= '0;
                r_py    <= '0;
                r_last  <= 1'b1;
                r_empty <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_status.rad_eq    = (r_rx == r_ry);
    assign o_status.rx_zero   = (r_rx == '0);
    assign o_status.ry_zero   = (r_ry == '0);
    assign o_status.circ_more = (r_x < r_y);
    assign o_status.r1_more   = (r_dx < r_dy);
    assign o_status.r2_more   = (r_y != '0);

    assign o_point_x   = r_px;
    assign o_point_y   = r_py;
    assign o_last      = r_last;
    assign o_empty_res = r_empty;

endmodule

`default_nettype wire

// ----- src/mea_chk.sv -----
// ----------------------------------------------------------------------------
// mea_chk
// Port-level checks on the arc point generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "midpoint_ellipse_arc_points_assert.svh"

module mea_chk (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              i_in_ready,
    input wire logic                              i_out_valid,
    input wire logic                              i_out_ready,
    input wire logic signed [mea_pkg::COORD_W-1:0] i_point_x,
    input wire logic signed [mea_pkg::COORD_W-1:0] i_point_y,
    input wire logic                              i_last,
    input wire logic                              i_empty_res
);

    `MEA_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_point_x) && $stable(i_point_y) && $stable(i_last) && $stable(i_empty_res), "stalled point transaction changed")
    `MEA_ASSERT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready, "request taken while a request is in progress")
    `MEA_ASSERT(a_empty_form, i_clk, i_rst_n, i_out_valid && i_empty_res |-> i_last && i_point_x == 0 && i_point_y == 0, "empty result is not a zero final point")
    `MEA_ASSERT_NR(a_rst_quiet, i_clk, !i_rst_n |=> !i_out_valid, "point valid after reset")

endmodule

bind midpoint_ellipse_arc_points mea_chk u_mea_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_pt.valid),
    .i_out_ready (o_pt.ready),
    .i_point_x   (o_pt.point_x),
    .i_point_y   (o_pt.point_y),
    .i_last      (o_pt.last),
    .i_empty_res (o_pt.empty_res)
);

`default_nettype wire

// ----- verif/midpoint_ellipse_arc_points_tb.sv -----
// ----------------------------------------------------------------------------
// Testbench for the quarter-arc point generator
// Sends circle and ellipse requests through the request channel. A scoreboard
// predicts each request's run of arc points and checks every point transaction
// in order. Requests are directed corner cases first, then random ones. Each
// random phase uses a different mix of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_ellipse_arc_points_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_POINTS   = 64;
    localparam int PHASE_ITEMS  = 64;
    localparam int MAX_PRINTED  = 40;

    typedef struct {
        logic [mea_pkg::COORD_W-1:0] px;
        logic [mea_pkg::COORD_W-1:0] py;
        logic                        last;
        logic                        is_empty;
    } t_arc_point;

    typedef enum logic [1:0] {
        ARC_IDLE,
        ARC_CIRCLE,
        ARC_REGION_ONE,
        ARC_REGION_TWO
    } t_arc_phase;

    class arc_scoreboard;
        t_arc_point                expected_points[$];
        t_arc_point                run_points[$];
        int                        fail_count = 0;
        logic [mea_pkg::OFF_W-1:0] off_x = '0;
        logic [mea_pkg::OFF_W-1:0] off_y = '0;
        logic [17:0]               slope_x = '0;
        logic [17:0]               slope_y = '0;
        longint                    decision_q = 0;
        t_arc_phase                arc_phase = ARC_IDLE;

        function int pending();
            return expected_points.size();
        endfunction

        function longint floor_quarter(input longint v);
            if (v >= 0) return v / 4;
            return -((-v + 3) / 4);
        endfunction

        function void add_point(input longint cx, input longint cy,
                                input longint ox, input longint oy);
            t_arc_point pt;
            if (run_points.size() >= MAX_POINTS) return;
            pt.px       = 16'(cx + ox);
            pt.py       = 16'(cy + oy);
            pt.last     = 1'b0;
            pt.is_empty = 1'b0;
            run_points.insert(run_points.size(), pt);
        endfunction

        function void note_request(input logic [15:0] cx_in, input logic [15:0] cy_in,
                                   input logic [5:0] rx_in, input logic [5:0] ry_in);
            longint     cx, cy, rx, ry, rx2, ry2, x, y, dx, dy, f, i, j;
            t_arc_point pt;
            cx = longint'($signed(cx_in));
            cy = longint'($signed(cy_in));
            rx = longint'(rx_in);
            ry = longint'(ry_in);
            if (rx > longint'(mea_pkg::RADIUS_MAX)) rx = longint'(mea_pkg::RADIUS_MAX);
            if (ry > longint'(mea_pkg::RADIUS_MAX)) ry = longint'(mea_pkg::RADIUS_MAX);
            run_points.delete();
            if (rx == ry) begin
                arc_phase = ARC_CIRCLE;
                i = 0;
                j = rx;
                f = 1 - rx;
                while (i < j && run_points.size() < MAX_POINTS) begin
                    i++;
                    if (f < 0) begin
                        f += 2 * i - 1;
                    end else begin
                        f += 2 * (i - j);
                        j--;
                    end
                    add_point(cx, cy, i, j);
                    add_point(cx, cy, j, i);
                end
                off_x      = 7'(i);
                off_y      = 7'(j);
                decision_q = f;
            end else begin
                rx2 = rx * rx;
                ry2 = ry * ry;
                x   = 0;
                y   = ry;
                dx  = 0;
                dy  = 2 * rx2 * ry;
                arc_phase = ARC_REGION_ONE;
                f = floor_quarter(4 * (ry2 - rx2 * ry) + rx2 + 2);
                while (dx < dy && run_points.size() < MAX_POINTS) begin
                    if (f >= 0) begin
                        y--;
                        dy -= 2 * rx2;
                        f  -= dy;
                    end
                    x++;
                    dx += 2 * ry2;
                    f  += dx + ry2;
                    add_point(cx, cy, x, y);
                end
                arc_phase = ARC_REGION_TWO;
                f = floor_quarter(4 * (ry2 * (x * x + x) + rx2 * (y - 1) * (y - 1)
                                       - rx2 * ry2) + ry2 + 2);
                while (y > 0 && run_points.size() < MAX_POINTS) begin
                    if (f <= 0) begin
                        x++;
                        dx += 2 * ry2;
                        f  += dx;
                    end
                    y--;
                    dy -= 2 * rx2;
                    f  += rx2 - dy;
                    add_point(cx, cy, x, y);
                end
                off_x      = 7'(x);
                off_y      = 7'(y);
                slope_x    = 18'(dx);
                slope_y    = 18'(dy);
                decision_q = f;
            end
            arc_phase = ARC_IDLE;
            if (run_points.size() == 0) begin
                pt.px       = '0;
                pt.py       = '0;
                pt.last     = 1'b1;
                pt.is_empty = 1'b1;
                expected_points.insert(expected_points.size(), pt);
            end else begin
                for (int k = 0; k < run_points.size(); k++) begin
                    pt      = run_points[k];
                    pt.last = (k == run_points.size() - 1);
                    expected_points.insert(expected_points.size(), pt);
                end
            end
        endfunction

        task report(input string what, input longint got, input longint want);
            fail_count++;
            if (fail_count <= MAX_PRINTED)
                $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got,
                         want);
        endtask

        task check_point(input logic [15:0] px, input logic [15:0] py,
                         input logic last, input logic is_empty);
            t_arc_point want;
            if (expected_points.size() == 0) begin
                report("point transaction with nothing pending, point_x", px, 0);
            end else begin
                want = expected_points.pop_front();
                if (px !== want.px) report("point_x", px, want.px);
                if (py !== want.py) report("point_y", py, want.py);
                if (last !== want.last) report("last", last, want.last);
                if (is_empty !== want.is_empty) report("empty_res", is_empty, want.is_empty);
            end
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   idle_pct  = 0;
    int   stall_pct = 0;

    arc_scoreboard sb = new();

    mea_req_if req_if ();
    mea_pt_if  pt_if ();

    midpoint_ellipse_arc_points u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_pt    (pt_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        pt_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready)
            sb.note_request(req_if.center_x, req_if.center_y, req_if.radius_x,
                            req_if.radius_y);
        if (i_rst_n && pt_if.valid && pt_if.ready)
            sb.check_point(pt_if.point_x, pt_if.point_y, pt_if.last, pt_if.empty_res);
    end

    task send_request(input logic [15:0] cx, input logic [15:0] cy,
                      input logic [5:0] rx, input logic [5:0] ry);
        while ($urandom_range(99) < idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.center_x <= cx;
        req_if.center_y <= cy;
        req_if.radius_x <= rx;
        req_if.radius_y <= ry;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    function automatic logic [5:0] pick_radius();
        int k;
        k = $urandom_range(99);
        if (k < 8) return 6'($urandom_range(63, 33));
        if (k < 14) return 6'd0;
        if (k < 40) return 6'($urandom_range(6));
        return 6'($urandom_range(32));
    endfunction

    task send_random_request();
        logic [5:0] rx;
        logic [5:0] ry;
        rx = pick_radius();
        if ($urandom_range(99) < 25) ry = rx;
        else ry = pick_radius();
        send_request(16'($urandom()), 16'($urandom()), rx, ry);
    endtask

    initial begin
        req_if.valid    <= 1'b0;
        req_if.center_x <= '0;
        req_if.center_y <= '0;
        req_if.radius_x <= '0;
        req_if.radius_y <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(16'h0000, 16'h0000, 6'd0, 6'd0);
        send_request(16'd100, 16'hFFCE, 6'd5, 6'd0);
        send_request(16'hFFF9, 16'd9, 6'd0, 6'd5);
        send_request(16'h0000, 16'h0000, 6'd1, 6'd1);
        send_request(16'h7FFF, 16'h7FFF, 6'd32, 6'd32);
        send_request(16'h8000, 16'h8000, 6'd32, 6'd32);
        send_request(16'hFFFF, 16'hFFFF, 6'd63, 6'd63);
        send_request(16'h0000, 16'h0000, 6'd32, 6'd1);
        send_request(16'h0000, 16'h0000, 6'd1, 6'd32);
        send_request(16'h0000, 16'h0000, 6'd0, 6'd32);
        send_request(16'h0000, 16'h0000, 6'd32, 6'd0);
        send_request(16'd1000, 16'd2000, 6'd2, 6'd3);
        send_request(16'hFC18, 16'h0000, 6'd3, 6'd2);
        send_request(16'h0000, 16'h0000, 6'd63, 6'd17);
        send_request(16'h0000, 16'h0000, 6'd40, 6'd0);
        send_request(16'd5, 16'd5, 6'd0, 6'd63);
        send_request(16'h0000, 16'h0000, 6'd31, 6'd32);
        send_request(16'h7FFF, 16'h8000, 6'd20, 6'd7);
        send_request(16'h0000, 16'h0000, 6'd1, 6'd2);
        send_request(16'h0000, 16'h0000, 6'd2, 6'd1);
        send_request(16'h0000, 16'h0000, 6'd63, 6'd32);
        send_request(16'hFFFE, 16'd3, 6'd7, 6'd7);
        send_request(16'h5555, 16'hAAAA, 6'd42, 6'd21);

        for (int phase_sel = 0; phase_sel < 4; phase_sel++) begin
            case (phase_sel)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 78; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 78; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            repeat (PHASE_ITEMS) send_random_request();
        end
        req_if.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
